// ----- rtl/image_intensity_histogram_core_macros.svh -----
// Assertion macros for the intensity histogram checker.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef IMAGE_INTENSITY_HISTOGRAM_CORE_MACROS_SVH
`define IMAGE_INTENSITY_HISTOGRAM_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IIH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IIH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/iih_pkg.sv -----
// Shared types and constants for the intensity histogram core.
// No dependencies; every other file but the macro header uses it by scoped names.
`timescale 1ns / 1ps

package iih_pkg;

	// Field widths
	localparam int PIX_W      = 17;
	localparam int IDX_W      = 8;
	localparam int N_W        = 9;
	localparam int WID_W      = 9;
	localparam int RCP_W      = 17;
	localparam int VAL_W      = 8;
	localparam int TOTAL_W    = 21;
	localparam int LOW_W      = 16;
	localparam int HIGH_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Opcodes; the fourth code is ignored
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd1;

	localparam logic [VAL_W-1:0] VAL_MAX = 8'hFF;

	// Configuration as seen by the front end
	typedef struct packed {
		logic [N_W-1:0]   n;
		logic [WID_W-1:0] w;
		logic [RCP_W-1:0] rcp;
		logic             fmt;
		logic             busy;
	} cfg_t;

	// Classified word passed from front end to back end
	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  addr;
		logic              bad;
		logic [LOW_W-1:0]  lo;
		logic [HIGH_W-1:0] hi;
	} entry_t;

endpackage

// ----- rtl/image_intensity_histogram_core.sv -----
// A read result is registered after front stages 1 and 2, the queue and the back end.
// Front end takes one word per cycle unless full; back end reads memory on take, then
// writes back an add or loads a read when output is free; a clear ends on take. A 4-word
// queue sits between. A bin_count write holds full high, cfg_ready low while the serial
// divider runs. Reset clears control and all bin valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module image_intensity_histogram_core #(
	parameter int MAX_BINS   = 256,
	parameter int COUNT_BITS = 21
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      opcode,
	input  logic [iih_pkg::PIX_W-1:0]       pixel_value,
	input  logic [iih_pkg::IDX_W-1:0]       bin_index,
	output logic                            empty,
	input  logic                            pop,
	output logic [iih_pkg::TOTAL_W-1:0]     bin_total,
	output logic [iih_pkg::LOW_W-1:0]       bin_low,
	output logic [iih_pkg::HIGH_W-1:0]      bin_high,
	output logic                            bad_index,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iih_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iih_pkg::CFG_DATA_W-1:0]  cfg_data
);

	iih_pkg::cfg_t   cfg;
	iih_pkg::entry_t q_wdata;
	iih_pkg::entry_t q_rdata;
	logic            q_wr;
	logic            q_rd;
	logic            q_full;
	logic            q_empty;

	// Configuration and width divider
	iih_cfg #(
		.MAX_BINS (MAX_BINS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Accept and classify
	iih_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.pixel_value (pixel_value),
		.bin_index   (bin_index),
		.cfg         (cfg),
		.q_wr        (q_wr),
		.q_wdata     (q_wdata),
		.q_full      (q_full)
	);

	// Decouple front and back
	iih_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Count and answer
	iih_back #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.q_rdata   (q_rdata),
		.empty     (empty),
		.pop       (pop),
		.bin_total (bin_total),
		.bin_low   (bin_low),
		.bin_high  (bin_high),
		.bad_index (bad_index)
	);

endmodule

// ----- rtl/iih_cfg.sv -----
// Configuration registers and the shared serial divider that derives
// bin width and its reciprocal. Depends on iih_pkg.
`timescale 1ns / 1ps

module iih_cfg #(
	parameter int MAX_BINS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iih_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iih_pkg::CFG_DATA_W-1:0]  cfg_data,
	output iih_pkg::cfg_t                   cfg
);

	typedef enum logic [2:0] {
		CS_IDLE  = 3'b001,
		CS_WIDTH = 3'b010,
		CS_RECIP = 3'b100
	} cstate_t;

	localparam int N_RST = (16 > MAX_BINS) ? MAX_BINS : 16;
	localparam int W_RST = (256 + N_RST - 1) / N_RST;
	localparam int R_RST = 65536 / W_RST + 1;
	localparam int STEPS = iih_pkg::RCP_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [iih_pkg::N_W-1:0] N_MAX = iih_pkg::N_W'(MAX_BINS);

	cstate_t                       state_q;
	logic [iih_pkg::N_W-1:0]       n_q;
	logic [iih_pkg::WID_W-1:0]     w_q;
	logic [iih_pkg::RCP_W-1:0]     rcp_q;
	logic                          fmt_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [iih_pkg::RCP_W-1:0]     dq_q;
	logic [iih_pkg::WID_W-1:0]     rem_q;
	logic [iih_pkg::WID_W-1:0]     dsr_q;

	logic                          wr;
	logic                          wr_count;
	logic [iih_pkg::N_W-1:0]       n_clamp;
	logic [iih_pkg::WID_W:0]       trial;
	logic                          ge;
	logic [iih_pkg::WID_W-1:0]     rem_nx;
	logic [iih_pkg::RCP_W-1:0]     dq_nx;
	logic                          last;
	logic [iih_pkg::WID_W-1:0]     w_nx;
	logic [iih_pkg::RCP_W-1:0]     rcp_nx;

	assign cfg_ready = (state_q == CS_IDLE);
	assign wr        = cfg_valid && cfg_ready;
	assign wr_count  = wr && (cfg_index == iih_pkg::REG_BIN_COUNT);

	// Clamp the requested bin count into 1..MAX_BINS
	always_comb begin
		if (cfg_data == '0) begin
			n_clamp = iih_pkg::N_W'(1);
		end else if (cfg_data > N_MAX) begin
			n_clamp = N_MAX;
		end else begin
			n_clamp = cfg_data;
		end
	end

	// One restoring divide step: shift in a dividend bit, subtract if it fits
	assign trial  = {rem_q, dq_q[iih_pkg::RCP_W-1]};
	assign ge     = (trial >= {1'b0, dsr_q});
	assign rem_nx = ge ? iih_pkg::WID_W'(trial - {1'b0, dsr_q}) : trial[iih_pkg::WID_W-1:0];
	assign dq_nx  = {dq_q[iih_pkg::RCP_W-2:0], ge};
	assign last   = (cnt_q == CNT_W'(STEPS - 1));
	// Width rounds up; reciprocal is floor(65536 / w) + 1
	assign w_nx   = dq_nx[iih_pkg::WID_W-1:0] + iih_pkg::WID_W'(rem_nx != '0);
	assign rcp_nx = dq_nx + iih_pkg::RCP_W'(1);

	// Control and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			n_q     <= iih_pkg::N_W'(N_RST);
			w_q     <= iih_pkg::WID_W'(W_RST);
			rcp_q   <= iih_pkg::RCP_W'(R_RST);
			fmt_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				CS_IDLE: begin
					if (wr_count) begin
						n_q     <= n_clamp;
						cnt_q   <= '0;
						state_q <= CS_WIDTH;
					end else if (wr && (cfg_index == iih_pkg::REG_PIXEL_FORMAT)) begin
						fmt_q <= cfg_data[0];
					end
				end
				CS_WIDTH: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						w_q     <= w_nx;
						cnt_q   <= '0;
						state_q <= CS_RECIP;
					end
				end
				CS_RECIP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						rcp_q   <= rcp_nx;
						cnt_q   <= '0;
						state_q <= CS_IDLE;
					end
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	// Divider datapath: 256 / n first, then 65536 / w
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE) begin
			if (wr_count) begin
				dq_q  <= iih_pkg::RCP_W'(256);
				rem_q <= '0;
				dsr_q <= n_clamp;
			end
		end else if (state_q == CS_WIDTH && last) begin
			dq_q  <= iih_pkg::RCP_W'(65536);
			rem_q <= '0;
			dsr_q <= w_nx;
		end else begin
			dq_q  <= dq_nx;
			rem_q <= rem_nx;
		end
	end

	assign cfg.n    = n_q;
	assign cfg.w    = w_q;
	assign cfg.rcp  = rcp_q;
	assign cfg.fmt  = fmt_q;
	assign cfg.busy = (state_q != CS_IDLE);

endmodule

// ----- rtl/iih_queue.sv -----
// Short FIFO of classified words between front end and back end.
// Depends on iih_pkg for the word type.
`timescale 1ns / 1ps

module iih_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  iih_pkg::entry_t wr_data,
	input  logic            rd_en,
	output iih_pkg::entry_t rd_data,
	output logic            full,
	output logic            empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	iih_pkg::entry_t     slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (cnt_q == (PTR_W + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (PTR_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (PTR_W + 1)'(1);
			end
		end
	end

	// Store incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/iih_front.sv -----
// Front end: accepts items, maps pixels to bins and reads to bounds,
// and pushes classified words into the queue. Depends on iih_pkg.
`timescale 1ns / 1ps

module iih_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   opcode,
	input  logic [iih_pkg::PIX_W-1:0]    pixel_value,
	input  logic [iih_pkg::IDX_W-1:0]    bin_index,
	input  iih_pkg::cfg_t                cfg,
	output logic                         q_wr,
	output iih_pkg::entry_t              q_wdata,
	input  logic                         q_full
);

	localparam int SCL_W  = iih_pkg::PIX_W + 8;
	localparam int PROD_W = iih_pkg::VAL_W + iih_pkg::RCP_W;

	logic                          vld_s1;
	logic [1:0]                    op_s1;
	logic [iih_pkg::PIX_W-1:0]     pix_s1;
	logic [iih_pkg::IDX_W-1:0]     idx_s1;

	logic                          vld_s2;
	logic [1:0]                    op_s2;
	logic [iih_pkg::VAL_W-1:0]     v_s2;
	logic [iih_pkg::IDX_W-1:0]     idx_s2;
	logic [iih_pkg::HIGH_W-1:0]    lo_s2;
	logic                          bad_s2;

	logic                          accept;
	logic                          s1_adv;
	logic                          s2_adv;
	logic [SCL_W-1:0]              scaled;
	logic [iih_pkg::VAL_W-1:0]     v;
	logic [iih_pkg::HIGH_W-1:0]    lo_full;
	logic                          bad;
	logic [PROD_W-1:0]             prod;
	logic [iih_pkg::HIGH_W-1:0]    hi_full;
	logic                          is_read;

	assign s2_adv = !vld_s2 || !q_full;
	assign s1_adv = !vld_s1 || s2_adv;
	assign full   = cfg.busy || !s1_adv;
	assign accept = push && !full;

	// Stage 1: pixel to intensity, read index to lower bound
	assign scaled = {pix_s1, 8'd0} - {8'd0, pix_s1};

	always_comb begin
		if (cfg.fmt) begin
			if (scaled[SCL_W-1:16] > 9'(iih_pkg::VAL_MAX)) begin
				v = iih_pkg::VAL_MAX;
			end else begin
				v = scaled[23:16];
			end
		end else begin
			if (pix_s1 > iih_pkg::PIX_W'(iih_pkg::VAL_MAX)) begin
				v = iih_pkg::VAL_MAX;
			end else begin
				v = pix_s1[iih_pkg::VAL_W-1:0];
			end
		end
	end

	assign lo_full = iih_pkg::HIGH_W'({9'd0, idx_s1} * {8'd0, cfg.w});
	assign bad     = ({1'b0, idx_s1} >= cfg.n);

	// Stage 2: bin by reciprocal multiply, upper bound by add
	assign prod    = {{iih_pkg::RCP_W{1'b0}}, v_s2} * {8'd0, cfg.rcp};
	assign hi_full = lo_s2 + {8'd0, cfg.w};
	assign is_read = (op_s2 == iih_pkg::OP_READ);

	// The bin never exceeds n - 1 since n * w >= 256
	always_comb begin
		q_wdata.op   = op_s2;
		q_wdata.addr = is_read ? idx_s2 : prod[23:16];
		q_wdata.bad  = is_read && bad_s2;
		q_wdata.lo   = (is_read && !bad_s2) ? lo_s2[iih_pkg::LOW_W-1:0] : '0;
		q_wdata.hi   = (is_read && !bad_s2) ? hi_full : '0;
	end

	// Drop the unused opcode here
	assign q_wr = vld_s2 && !q_full && (op_s2 == iih_pkg::OP_CLEAR ||
		op_s2 == iih_pkg::OP_ADD || op_s2 == iih_pkg::OP_READ);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				vld_s1 <= accept;
			end
			if (s2_adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (s1_adv && accept) begin
			op_s1  <= opcode;
			pix_s1 <= pixel_value;
			idx_s1 <= bin_index;
		end
		if (s2_adv && vld_s1) begin
			op_s2  <= op_s1;
			v_s2   <= v;
			idx_s2 <= idx_s1;
			lo_s2  <= lo_full;
			bad_s2 <= bad;
		end
	end

endmodule

// ----- rtl/iih_back.sv -----
// Back end: counter memory with per-bin valid bits, read-modify-write
// for adds, and the result register. Depends on iih_pkg.
`timescale 1ns / 1ps

module iih_back #(
	parameter int MAX_BINS   = 256,
	parameter int COUNT_BITS = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_rd,
	input  iih_pkg::entry_t               q_rdata,
	output logic                          empty,
	input  logic                          pop,
	output logic [iih_pkg::TOTAL_W-1:0]   bin_total,
	output logic [iih_pkg::LOW_W-1:0]     bin_low,
	output logic [iih_pkg::HIGH_W-1:0]    bin_high,
	output logic                          bad_index
);

	typedef enum logic [1:0] {
		BS_IDLE = 2'b01,
		BS_EXEC = 2'b10
	} bstate_t;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	bstate_t                      state_q;
	iih_pkg::entry_t              cur_q;
	logic [COUNT_BITS-1:0]        rd_data_q;
	logic [COUNT_BITS-1:0]        mem [MAX_BINS];
	logic [MAX_BINS-1:0]          valid_q;
	logic                         out_vld_q;

	logic                         take;
	logic [AW-1:0]                cur_addr;
	logic [AW-1:0]                head_addr;
	logic [COUNT_BITS-1:0]        cnt;
	logic [COUNT_BITS-1:0]        cnt_inc;
	logic [31:0]                  cnt_ext;
	logic                         out_free;
	logic                         out_load;
	logic                         mem_we;
	logic                         done;

	assign take      = (state_q == BS_IDLE) && !q_empty;
	assign q_rd      = take;
	assign cur_addr  = cur_q.addr[AW-1:0];
	assign head_addr = q_rdata.addr[AW-1:0];

	// A bin never written since the last clear reads as zero
	assign cnt     = valid_q[cur_addr] ? rd_data_q : '0;
	assign cnt_inc = (&cnt) ? cnt : cnt + COUNT_BITS'(1);
	assign cnt_ext = 32'(cnt);

	assign out_free = !out_vld_q || pop;
	assign mem_we   = (state_q == BS_EXEC) && (cur_q.op == iih_pkg::OP_ADD);
	assign out_load = (state_q == BS_EXEC) && (cur_q.op == iih_pkg::OP_READ) && out_free;
	assign done     = mem_we || out_load;

	// Sequencer, valid bits and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BS_IDLE;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				BS_IDLE: begin
					if (take && q_rdata.op != iih_pkg::OP_CLEAR) begin
						state_q <= BS_EXEC;
					end
				end
				BS_EXEC: begin
					if (done) begin
						state_q <= BS_IDLE;
					end
				end
				default: begin
					state_q <= BS_IDLE;
				end
			endcase

			if (take && q_rdata.op == iih_pkg::OP_CLEAR) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[cur_addr] <= 1'b1;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Counter memory: read on take, write back on add
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_addr] <= cnt_inc;
		end
		if (take) begin
			rd_data_q <= mem[head_addr];
		end
	end

	// Hold current word and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_rdata;
		end
		if (out_load) begin
			bin_total <= cur_q.bad ? '0 : cnt_ext[iih_pkg::TOTAL_W-1:0];
			bin_low   <= cur_q.lo;
			bin_high  <= cur_q.hi;
			bad_index <= cur_q.bad;
		end
	end

	assign empty = !out_vld_q;

endmodule

// ----- rtl/iih_checker.sv -----
// Port-level checks for the intensity histogram core, bound to the top level.
// Depends on iih_pkg and image_intensity_histogram_core_macros.svh.
`timescale 1ns / 1ps
`include "image_intensity_histogram_core_macros.svh"

module iih_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [iih_pkg::TOTAL_W-1:0]   bin_total,
	input logic [iih_pkg::LOW_W-1:0]     bin_low,
	input logic [iih_pkg::HIGH_W-1:0]    bin_high,
	input logic                          bad_index
);

	// Out-of-range read carries an all-zero word
	`IIH_ASSERT(a_bad_zero, (!empty && bad_index) |-> (bin_total == '0 && bin_low == '0 && bin_high == '0), "bad index result not zeroed")

	// In-range bounds span one bin width of 1..256
	`IIH_ASSERT(a_bounds, (!empty && !bad_index) |-> (bin_high > {1'b0, bin_low} && (bin_high - {1'b0, bin_low}) <= 17'd256), "bin bounds inconsistent")

	// A waiting result holds until taken
	`IIH_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(bin_total) && $stable(bin_low) && $stable(bin_high) && $stable(bad_index)), "waiting result changed")

	// No result is shown in reset
	`IIH_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> empty, "result shown during reset")

endmodule

bind image_intensity_histogram_core iih_checker u_iih_checker (.*);

// ----- tb/image_intensity_histogram_core_tb.sv -----
// Testbench for image_intensity_histogram_core: directed table, then random phases per setting.
// Depends on iih_pkg and the core; predicts each read word and checks results in order.
`timescale 1ns / 1ps

module image_intensity_histogram_core_tb;

	localparam int          CLK_HALF = 4;
	localparam int          SETTLE   = 32;     // cycles to let queued adds/clears finish
	localparam int unsigned LIMIT    = 300000;
	localparam int          N_DIR    = 29;
	localparam int          N_PHASES = 12;
	localparam int          PHASE_WORDS = 70;
	localparam int          HOLD_CYCLES = 300;
	localparam int          MAX_REPORTS = 40;

	// Opcode and register index the block ignores
	localparam logic [1:0]                    OP_NONE    = 2'd3;
	localparam logic [iih_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

	typedef struct packed {
		logic [iih_pkg::TOTAL_W-1:0] total;
		logic [iih_pkg::LOW_W-1:0]   lo;
		logic [iih_pkg::HIGH_W-1:0]  hi;
		logic                        bad;
	} read_t;

	typedef struct packed {
		bit                             is_cfg;
		logic [iih_pkg::CFG_IDX_W-1:0]  cidx;
		logic [iih_pkg::CFG_DATA_W-1:0] cdata;
		logic [1:0]                     op;
		logic [iih_pkg::PIX_W-1:0]      pix;
		logic [iih_pkg::IDX_W-1:0]      idx;
		bit                             typed;
		read_t                          res;
	} stim_row_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b1;
	logic                           push        = 1'b0;
	logic                           full;
	logic [1:0]                     opcode      = iih_pkg::OP_CLEAR;
	logic [iih_pkg::PIX_W-1:0]      pixel_value = '0;
	logic [iih_pkg::IDX_W-1:0]      bin_index   = '0;
	logic                           empty;
	logic                           pop         = 1'b0;
	logic [iih_pkg::TOTAL_W-1:0]    bin_total;
	logic [iih_pkg::LOW_W-1:0]      bin_low;
	logic [iih_pkg::HIGH_W-1:0]     bin_high;
	logic                           bad_index;
	logic                           cfg_valid   = 1'b0;
	logic                           cfg_ready;
	logic [iih_pkg::CFG_IDX_W-1:0]  cfg_index   = iih_pkg::REG_BIN_COUNT;
	logic [iih_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

	// Predictor state
	logic [iih_pkg::TOTAL_W-1:0]    bin_tally [256];
	logic [iih_pkg::CFG_DATA_W-1:0] cfg_bins;
	logic                           cfg_frac;
	read_t                          read_q [$];

	int          errors      = 0;
	int          words_sent  = 0;
	int          reads_seen  = 0;
	int          cfg_writes  = 0;
	int          hold_reqs   = 0;
	int          hold_seen   = 0;
	int          hold_left   = 0;
	int unsigned rx_tick     = 0;
	int unsigned cyc         = 0;
	read_t       rx_exp, rx_got;

	// Directed words; typed results only where obvious
	stim_row_t dir_rows [0:N_DIR-1] = '{
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd0,   1, '{21'd0, 16'd0,   17'd16,  1'b0}},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd15,  1, '{21'd0, 16'd240, 17'd256, 1'b0}},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd16,  1, '{21'd0, 16'd0,   17'd0,   1'b1}},
		'{0, '0, '0, iih_pkg::OP_READ,  17'h1FFFF, 8'd255, 1, '{21'd0, 16'd0,   17'd0,   1'b1}},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd0,     8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd255,   8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd256,   8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'h1FFFF, 8'hFF,  0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd15,    8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd16,    8'd0,   0, '0},
		'{0, '0, '0, OP_NONE,           17'h1FFFF, 8'hFF,  0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd15,  0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd1,   0, '0},
		'{0, '0, '0, iih_pkg::OP_CLEAR, 17'd0,     8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd15,  1, '{21'd0, 16'd240, 17'd256, 1'b0}},
		'{1, iih_pkg::REG_PIXEL_FORMAT, 9'd1, iih_pkg::OP_CLEAR, 17'd0, 8'd0, 0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd65536, 8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd65535, 8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'h1FFFF, 8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd257,   8'd0,   0, '0},
		'{0, '0, '0, iih_pkg::OP_ADD,   17'd258,   8'd0,   0, '0},
		'{1, iih_pkg::REG_BIN_COUNT, 9'd0, iih_pkg::OP_CLEAR, 17'd0, 8'd0, 0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd1,   1, '{21'd0, 16'd0,   17'd0,   1'b1}},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd0,   0, '0},
		'{1, iih_pkg::REG_BIN_COUNT, 9'd511, iih_pkg::OP_CLEAR, 17'd0, 8'd0, 0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd255, 0, '0},
		'{1, iih_pkg::REG_BIN_COUNT, 9'd300, iih_pkg::OP_CLEAR, 17'd0, 8'd0, 0, '0},
		'{0, '0, '0, iih_pkg::OP_READ,  17'd0,     8'd0,   0, '0}
	};

	// Settings walked by the random phases; the last one is drawn at random
	int unsigned phase_bins [N_PHASES] = '{1, 256, 0, 300, 511, 3, 7, 100, 256, 17, 129, 0};
	bit          phase_frac [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1, 0};

	image_intensity_histogram_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.pixel_value(pixel_value),
		.bin_index  (bin_index),
		.empty      (empty),
		.pop        (pop),
		.bin_total  (bin_total),
		.bin_low    (bin_low),
		.bin_high   (bin_high),
		.bad_index  (bad_index),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Bail out on a hung run
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results pending", $time, cyc,
				read_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Effective bin count: zero means one, above 256 saturates
	function automatic int unsigned bins_in_use();
		if (cfg_bins == 0)
			return 1;
		if (cfg_bins > 256)
			return 256;
		return cfg_bins;
	endfunction

	// Apply one word to the histogram; hand back the read word it yields
	function automatic void hist_apply(input logic [1:0] op,
			input logic [iih_pkg::PIX_W-1:0] pix, input logic [iih_pkg::IDX_W-1:0] idx,
			output bit has, output read_t r);
		int unsigned n, w, v, b, lo;
		n   = bins_in_use();
		w   = (256 + n - 1) / n;
		has = 0;
		r   = '0;
		case (op)
			iih_pkg::OP_CLEAR: begin
				for (int i = 0; i < 256; i++)
					bin_tally[i] = '0;
			end
			iih_pkg::OP_ADD: begin
				v = pix;
				if (cfg_frac)
					v = (v * 255) >> 16;
				if (v > 255)
					v = 255;
				b = v / w;
				if (b >= n)
					b = n - 1;
				if (bin_tally[b] != '1)
					bin_tally[b] = bin_tally[b] + 1'b1;
			end
			iih_pkg::OP_READ: begin
				has = 1;
				if (idx >= n) begin
					r.bad = 1'b1;
				end else begin
					lo      = idx * w;
					r.total = bin_tally[idx];
					r.lo    = lo[iih_pkg::LOW_W-1:0];
					r.hi    = iih_pkg::HIGH_W'(lo + w);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endfunction

	// Offer one word, hold it until accepted, then predict
	task automatic send_word(input logic [1:0] op, input logic [iih_pkg::PIX_W-1:0] pix,
			input logic [iih_pkg::IDX_W-1:0] idx, input bit typed, input read_t typed_res);
		bit    has;
		read_t r;
		push        <= 1'b1;
		opcode      <= op;
		pixel_value <= pix;
		bin_index   <= idx;
		do
			@(posedge clk);
		while (full);
		hist_apply(op, pix, idx, has, r);
		if (has)
			read_q.push_back(typed ? typed_res : r);
		words_sent++;
	endtask

	// Drain all pending reads, let the back end settle, then write one register
	task automatic write_reg(input logic [iih_pkg::CFG_IDX_W-1:0] ridx,
			input logic [iih_pkg::CFG_DATA_W-1:0] val);
		push <= 1'b0;
		while (read_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ridx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (ridx == iih_pkg::REG_BIN_COUNT)
			cfg_bins = val;
		else if (ridx == iih_pkg::REG_PIXEL_FORMAT)
			cfg_frac = val[0];
		cfg_writes++;
	endtask

	// Receiver: check each popped word, stall on a rotating pattern, hold off on request
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			rx_got = '{bin_total, bin_low, bin_high, bad_index};
			if (read_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected word, expected none, got total %0d low %0d high %0d bad %0d",
						$time, bin_total, bin_low, bin_high, bad_index);
			end else begin
				rx_exp = read_q.pop_front();
				check_field("bin_total", rx_exp.total, rx_got.total);
				check_field("bin_low", rx_exp.lo, rx_got.lo);
				check_field("bin_high", rx_exp.hi, rx_got.hi);
				check_field("bad_index", rx_exp.bad, rx_got.bad);
				reads_seen++;
			end
		end
		rx_tick <= rx_tick + 1;
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			case (rx_tick[8:7])
				2'd0:    pop <= 1'b1;
				2'd1:    pop <= ($urandom_range(0, 1) == 0);
				2'd2:    pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Stimulus
	initial begin : stim
		logic [1:0]                op;
		logic [iih_pkg::PIX_W-1:0] pix;
		logic [iih_pkg::IDX_W-1:0] idx;
		int unsigned               n, pick, count, burst_left, gap;
		bit                        idle_on;

		// Assert reset once every process is waiting on its edge
		arst_n <= 1'b0;
		for (int i = 0; i < 256; i++)
			bin_tally[i] = '0;
		cfg_bins = 9'd16;
		cfg_frac = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unused index must leave everything alone
		write_reg(REG_UNUSED, 9'h1FF);

		// Directed table
		for (int k = 0; k < N_DIR; k++) begin
			if (dir_rows[k].is_cfg)
				write_reg(dir_rows[k].cidx, dir_rows[k].cdata);
			else
				send_word(dir_rows[k].op, dir_rows[k].pix, dir_rows[k].idx,
					dir_rows[k].typed, dir_rows[k].res);
		end

		// Random phases, one register setting each
		for (int p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 1) begin
				write_reg(iih_pkg::REG_BIN_COUNT,
					iih_pkg::CFG_DATA_W'($urandom_range(0, 511)));
				write_reg(iih_pkg::REG_PIXEL_FORMAT,
					iih_pkg::CFG_DATA_W'($urandom_range(0, 1)));
			end else begin
				write_reg(iih_pkg::REG_BIN_COUNT, iih_pkg::CFG_DATA_W'(phase_bins[p]));
				write_reg(iih_pkg::REG_PIXEL_FORMAT, iih_pkg::CFG_DATA_W'(phase_frac[p]));
			end
			n          = bins_in_use();
			idle_on    = (p % 3 != 2);
			count      = 0;
			burst_left = 0;

			// Hold the receiver off and pile up reads until the block backs up
			if (p == 4) begin
				hold_reqs++;
				for (int j = 0; j < 40; j++) begin
					send_word(iih_pkg::OP_READ,
						iih_pkg::PIX_W'($urandom_range(0, 131071)),
						iih_pkg::IDX_W'($urandom_range(0, 255)), 0, '0);
					count++;
				end
			end

			while (count < PHASE_WORDS) begin
				// Bursts with random gaps between them
				if (idle_on && burst_left == 0) begin
					gap        = $urandom_range(0, 8);
					burst_left = $urandom_range(1, 20);
					if (gap > 0) begin
						push <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				if (burst_left > 0)
					burst_left--;

				pick = $urandom_range(0, 99);
				if (pick < 3)
					op = iih_pkg::OP_CLEAR;
				else if (pick < 8)
					op = OP_NONE;
				else if (pick < 60)
					op = iih_pkg::OP_ADD;
				else
					op = iih_pkg::OP_READ;

				pick = $urandom_range(0, 99);
				if (pick < 85)
					pix = iih_pkg::PIX_W'(cfg_frac ? $urandom_range(0, 65536) :
						$urandom_range(0, 255));
				else if (pick < 95)
					pix = iih_pkg::PIX_W'($urandom_range(0, 131071));
				else
					case ($urandom_range(0, 4))
						0:       pix = 17'd0;
						1:       pix = 17'd255;
						2:       pix = 17'd256;
						3:       pix = 17'd65536;
						default: pix = 17'h1FFFF;
					endcase

				if ($urandom_range(0, 99) < 85)
					idx = iih_pkg::IDX_W'($urandom_range(0, n - 1));
				else
					idx = iih_pkg::IDX_W'($urandom_range(0, 255));

				send_word(op, pix, idx, 0, '0);
				if (op != OP_NONE)
					count++;
			end
		end

		// Wait out the last results
		push <= 1'b0;
		while (read_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d words and %0d checked reads across %0d register writes,",
			words_sent, reads_seen, cfg_writes);
		$display("bin counts from 0 to 511 in integer and fractional pixel formats.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
